// File: rtl/abm_pkg.sv
// Package for the allocation bitmap find-first block: sizes, field widths, op codes.
// No dependencies; used by allocation_bitmap_find_first.
package abm_pkg;

  // Word width must be a power of two: bit position and word number are bit slices.
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = 16;
  localparam int CAPACITY   = WORD_BITS * WORD_COUNT;

  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WORD_AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam int OP_W  = 3;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
  localparam int IN_PAD  = IN_W - OP_W - IDX_W;
  localparam int OUT_PAD = OUT_W - 1 - IDX_W - 1;

  localparam logic [CNT_W-1:0] BITS_IN_USE_RST = CNT_W'(1024);

  localparam logic [OP_W-1:0] OP_FIND_SET = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND_CLR = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST     = 3'd2;
  localparam logic [OP_W-1:0] OP_SET      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
  localparam logic [OP_W-1:0] OP_FILL1    = 3'd5;
  localparam logic [OP_W-1:0] OP_FILL0    = 3'd6;

endpackage

// File: rtl/abm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/allocation_bitmap_find_first.sv
// Allocation bitmap with find-first-set / find-first-clear, test, set, clear and fills.
// Depends on abm_pkg and abm_ram (bitmap words, registered read).
// Ops go START, then MOD (test/set/clear) or SCAN and ENC (search hit), then DONE;
// fills, unused ops, out-of-range indices and zero-count searches go straight to DONE, as
// does a search miss at the last word. Next beat is taken in the cycle after the result loads.
// Reset: bitmap reads as all zero (per-word valid bits cleared), bits_in_use = 1024.
module allocation_bitmap_find_first (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [abm_pkg::CNT_W-1:0]       cfg_wdata_i,   // bits_in_use
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [abm_pkg::IN_W-1:0]        s_axis_tdata_i,  // op[2:0], bit_index[12:3]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [abm_pkg::OUT_W-1:0]       m_axis_tdata_o   // ok[0], found_index[10:1],
                                                           // bit_value[11]
);

  localparam int WB = abm_pkg::WORD_BITS;
  localparam int BW = abm_pkg::BIT_W;
  localparam int AW = abm_pkg::WORD_AW;
  localparam int CW = abm_pkg::CNT_W;
  localparam int XW = abm_pkg::IDX_W;
  localparam int OW = abm_pkg::OP_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_ENC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   bits_in_use_q;
  logic [OW-1:0]   op_q;
  logic [XW-1:0]   idx_q;
  logic [abm_pkg::WORD_COUNT-1:0] valid_q, valid_d;
  logic            fill_q, fill_d;
  logic            vld_q;
  logic [AW-1:0]   data_w_q, data_w_d;
  logic [WB-1:0]   hit_word_q, hit_word_d;
  logic [AW-1:0]   hit_w_q, hit_w_d;
  logic            res_ok_q, res_ok_d;
  logic [XW-1:0]   res_found_q, res_found_d;
  logic            res_bit_q, res_bit_d;
  logic            m_valid_q, m_valid_d;
  logic [abm_pkg::OUT_W-1:0] m_data_q, m_data_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [WB-1:0]   ram_wdata, ram_rdata;

  logic [CW-1:0]   vcount, vcount_m1;
  logic [AW-1:0]   last_w, idx_word;
  logic [BW-1:0]   bit_pos, enc_j;
  logic [BW:0]     tail_bits;
  logic [WB-1:0]   eff, cand, word_mask, bit_mask;
  logic            in_range, in_accept, out_load;

  abm_ram #(.WIDTH(WB), .DEPTH(abm_pkg::WORD_COUNT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Effective count clamps to capacity.
  assign vcount    = (bits_in_use_q > CW'(abm_pkg::CAPACITY)) ? CW'(abm_pkg::CAPACITY)
                                                              : bits_in_use_q;
  assign vcount_m1 = vcount - CW'(1);
  assign last_w    = vcount_m1[BW +: AW];
  assign tail_bits = {1'b0, vcount_m1[BW-1:0]} + (BW+1)'(1);

  assign in_range = {1'b0, idx_q} < vcount;
  assign idx_word = idx_q[BW +: AW];
  assign bit_pos  = BW'(WB - 1) - idx_q[BW-1:0];
  assign bit_mask = WB'(1) << bit_pos;

  // Words never written since the last fill read as the fill value.
  assign eff = vld_q ? ram_rdata : {WB{fill_q}};

  // Index order runs from the MSB down; keep only the top tail_bits of the last word.
  assign word_mask = (data_w_q == last_w) ? ~({WB{1'b1}} >> tail_bits) : {WB{1'b1}};
  assign cand      = ((op_q == abm_pkg::OP_FIND_SET) ? eff : ~eff) & word_mask;

  always_comb begin
    enc_j = '0;
    for (int p = 0; p < WB; p++) begin
      if (hit_word_q[p]) begin
        enc_j = BW'(WB - 1 - p);
      end
    end
  end

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign out_load        = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    fill_d      = fill_q;
    data_w_d    = data_w_q;
    hit_word_d  = hit_word_q;
    hit_w_d     = hit_w_q;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_bit_d   = res_bit_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_word;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_START;
        end
      end
      S_START: begin
        res_ok_d    = 1'b0;
        res_found_d = '0;
        res_bit_d   = 1'b0;
        state_d     = S_DONE;
        case (op_q) inside
          abm_pkg::OP_FIND_SET, abm_pkg::OP_FIND_CLR: begin
            if (vcount != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              data_w_d  = '0;
              state_d   = S_SCAN;
            end
          end
          abm_pkg::OP_TEST, abm_pkg::OP_SET, abm_pkg::OP_CLEAR: begin
            if (in_range) begin
              ram_re    = 1'b1;
              ram_raddr = idx_word;
              state_d   = S_MOD;
            end
          end
          abm_pkg::OP_FILL1, abm_pkg::OP_FILL0: begin
            valid_d  = '0;
            fill_d   = (op_q == abm_pkg::OP_FILL1);
            res_ok_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_MOD: begin
        res_ok_d = 1'b1;
        state_d  = S_DONE;
        if (op_q == abm_pkg::OP_TEST) begin
          res_bit_d = eff[bit_pos];
        end else begin
          ram_we            = 1'b1;
          ram_wdata         = (op_q == abm_pkg::OP_SET) ? (eff | bit_mask) : (eff & ~bit_mask);
          valid_d[idx_word] = 1'b1;
        end
      end
      S_SCAN: begin
        // Read of the next word overlaps the check of the current one.
        ram_re    = 1'b1;
        ram_raddr = data_w_q + AW'(1);
        data_w_d  = data_w_q + AW'(1);
        if (cand != '0) begin
          hit_word_d = cand;
          hit_w_d    = data_w_q;
          state_d    = S_ENC;
        end else if (data_w_q == last_w) begin
          state_d = S_DONE;
        end
      end
      S_ENC: begin
        res_ok_d    = 1'b1;
        res_found_d = XW'({hit_w_q, enc_j});
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {{abm_pkg::OUT_PAD{1'b0}}, res_bit_q, res_found_q, res_ok_q};
    end else if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      bits_in_use_q <= abm_pkg::BITS_IN_USE_RST;
      valid_q       <= '0;
      fill_q        <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        bits_in_use_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= s_axis_tdata_i[OW-1:0];
      idx_q <= s_axis_tdata_i[OW +: XW];
    end
    if (ram_re) begin
      vld_q <= valid_q[ram_raddr];
    end
    data_w_q    <= data_w_d;
    hit_word_q  <= hit_word_d;
    hit_w_q     <= hit_w_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_bit_q   <= res_bit_d;
    m_data_q    <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !ram_we)
    else $error("bitmap write during word scan");

  a_enc_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC) |-> (hit_word_q != '0))
    else $error("leading-bit encode entered without a hit");

  a_fill_clears_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START && (op_q == abm_pkg::OP_FILL1 || op_q == abm_pkg::OP_FILL0))
    |=> (valid_q == '0))
    else $error("fill did not invalidate stored words");

  a_fail_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !res_ok_q) |-> (res_found_q == '0 && !res_bit_q))
    else $error("failed result carries nonzero fields");

endmodule
